FILE: hdl/rpn_stack_evaluator_top_defines.svh
// Assertion helpers for the stack evaluator
`ifndef RPN_STACK_EVALUATOR_TOP_DEFINES_SVH
`define RPN_STACK_EVALUATOR_TOP_DEFINES_SVH

`define RPN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rpn_pkg.sv
package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PARAM_SLOTS = 16;
    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int PIDX_W = 4;
    localparam int PSLOT_W = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;
    localparam int NPAR_W = 5;
    localparam int USED_W = 5;

    typedef enum logic [1:0] {
        OPN_WRITE = 2'd0,
        OPN_LIT   = 2'd1,
        OPN_PARAM = 2'd2,
        OPN_APPLY = 2'd3
    } opn_t;

    typedef enum logic [1:0] {
        AOP_ADD = 2'd0,
        AOP_SUB = 2'd1,
        AOP_MUL = 2'd2,
        AOP_DIV = 2'd3
    } aop_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_PARAM = 2'd1,
        ERR_STACK = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_BOTTOM,
        ST_OUT
    } state_t;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat_from(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = SAT_MAX;
        else if (v < -64'sh0000_0000_8000_0000)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: hdl/rpn_if.sv
interface rpn_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic signed [31:0] value;
    logic [3:0]        param_index;
    logic [1:0]        arith_op;
    logic              last;
    modport source (output valid, operation, value, param_index, arith_op, last,
                    input ready);
    modport sink (input valid, operation, value, param_index, arith_op, last,
                  output ready);
endinterface

interface rpn_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] result;
    logic [1:0]        error;
    modport source (output valid, result, error, input ready);
    modport sink (input valid, result, error, output ready);
endinterface

FILE: hdl/rpn_stack_evaluator_top.sv
// Postfix evaluator over Q16.16 operands.
// Channels: tok (input tokens), res (one result per token marked last).
// cfg_we/cfg_wdata write num_params; write it only while the block is idle.
// One token at a time: tok.ready is high only in the idle state.
// Each token reads the operand stack memory (synchronous read of the top
// two entries, one per port), then computes and writes back.
// A parameter write completes in the idle state; pushes, add and subtract
// go through read and exec; multiply adds a rounding state after exec;
// divide runs the radix-2 restoring divider after exec (a zero divisor is
// written back from exec without it). A token marked last then reads the
// bottom entry (fin, bottom states), and the result is held on res until
// taken; a stalled receiver blocks new tokens.
// Reset clears level, fault, used count, num_params and the parameter
// store (valid bits per slot); the stack memory is not cleared since only
// entries written in the current expression are read.
// Multiply is one 32x32 product, registered before rounding and saturation.
module rpn_stack_evaluator_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [4:0]    cfg_wdata,
    rpn_in_if.sink        tok,
    rpn_out_if.source     res
);
    import rpn_pkg::*;
`include "rpn_stack_evaluator_top_defines.svh"

    logic signed [31:0] stack_mem [STACK_DEPTH];
    logic signed [31:0] par_mem [PARAM_SLOTS];
    logic [PARAM_SLOTS-1:0] par_vld_reg;

    state_t state_reg, state_next;
    logic [LVL_W-1:0] level_reg;
    logic [USED_W-1:0] used_reg;
    logic fault_reg;
    logic [NPAR_W-1:0] npar_reg;

    logic [1:0] op_reg;
    logic [1:0] aop_reg;
    logic last_reg;
    logic [3:0] tok_idx_reg;
    logic signed [31:0] val_reg;
    logic signed [31:0] a_reg, b_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] res_reg;
    logic [1:0] err_reg;

    // divider: 48-bit magnitude dividend, 32-bit divisor
    logic [47:0] dq_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;

    logic [SP_W-1:0] ra_addr, rb_addr;
    logic signed [31:0] rd_a, rd_b;
    logic rd_en;

    logic wr_en;
    logic [SP_W-1:0] wr_addr;
    logic signed [31:0] wr_data;
    logic [LVL_W-1:0] level_next;
    logic fault_next;
    logic [USED_W-1:0] used_next;

    logic signed [31:0] alu_q;
    logic signed [63:0] pr_shift;
    logic [32:0] rem_try;
    logic [47:0] quo_mag;
    logic signed [48:0] quo_s;

    assign tok.ready = (state_reg == ST_IDLE);
    assign res.valid = (state_reg == ST_OUT);
    assign res.result = res_reg;
    assign res.error = err_reg;

    logic tok_fire;
    assign tok_fire = tok.valid && tok.ready;

    // stack memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_a <= stack_mem[ra_addr];
            rd_b <= stack_mem[rb_addr];
        end
    end

    // parameter store
    always_ff @(posedge clk)
    begin
        if (tok_fire && tok.operation == OPN_WRITE && 32'(tok.param_index) < PARAM_SLOTS)
            par_mem[tok.param_index[PSLOT_W-1:0]] <= tok.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_vld_reg <= '0;
            npar_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                npar_reg <= cfg_wdata;
            if (tok_fire && tok.operation == OPN_WRITE && 32'(tok.param_index) < PARAM_SLOTS)
                par_vld_reg[tok.param_index[PSLOT_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_fire)
        begin
            op_reg <= tok.operation;
            aop_reg <= tok.arith_op;
            last_reg <= tok.last;
            if (tok.operation == OPN_PARAM)
                val_reg <= (32'(tok.param_index) < PARAM_SLOTS
                            && par_vld_reg[tok.param_index[PSLOT_W-1:0]])
                           ? par_mem[tok.param_index[PSLOT_W-1:0]] : 32'sd0;
            else
                val_reg <= tok.value;
        end
    end

    always_comb
    begin
        rd_en = (state_reg == ST_READ) || (state_reg == ST_FIN);
        if (state_reg == ST_FIN)
        begin
            ra_addr = '0;
            rb_addr = '0;
        end
        else
        begin
            ra_addr = SP_W'(level_reg - LVL_W'(2));
            rb_addr = SP_W'(level_reg - LVL_W'(1));
        end
    end

    // multiply rounding: arithmetic shift floors
    assign pr_shift = prod_reg >>> 16;
    assign rem_try = {rem_reg[31:0], dq_reg[47]} - {1'b0, dvs_reg};
    assign quo_mag = dq_reg;
    assign quo_s = neg_reg ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});

    always_comb
    begin
        unique case (aop_reg)
            AOP_ADD: alu_q = sat_from(64'(a_reg) + 64'(b_reg));
            AOP_SUB: alu_q = sat_from(64'(a_reg) - 64'(b_reg));
            AOP_MUL: alu_q = sat_from(pr_shift);
            AOP_DIV: alu_q = sat_from(64'(quo_s));
            default: alu_q = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        wr_en = 1'b0;
        wr_addr = SP_W'(level_reg);
        wr_data = val_reg;
        level_next = level_reg;
        fault_next = fault_reg;
        used_next = used_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tok_fire && tok.operation != OPN_WRITE)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = last_reg ? ST_FIN : ST_IDLE;
                if (op_reg == OPN_APPLY)
                begin
                    if (level_reg < LVL_W'(2))
                        fault_next = 1'b1;
                    else if (aop_reg == AOP_DIV && b_reg != 0)
                        state_next = ST_DIV;
                    else if (aop_reg == AOP_MUL)
                        state_next = ST_MUL;
                    else
                    begin
                        wr_en = 1'b1;
                        wr_addr = SP_W'(level_reg - LVL_W'(2));
                        if (aop_reg == AOP_DIV)
                            wr_data = (a_reg > 0) ? SAT_MAX : (a_reg < 0) ? SAT_MIN : 32'sd0;
                        else
                            wr_data = alu_q;
                        level_next = level_reg - LVL_W'(1);
                    end
                end
                else
                begin
                    if (32'(level_reg) >= STACK_DEPTH)
                        fault_next = 1'b1;
                    else
                    begin
                        wr_en = 1'b1;
                        level_next = level_reg + LVL_W'(1);
                    end
                end
                if (op_reg == OPN_PARAM && USED_W'(tok_idx_reg) + USED_W'(1) > used_reg)
                    used_next = USED_W'(tok_idx_reg) + USED_W'(1);
            end
            ST_MUL:
            begin
                // product registered at exec; round and write back now
                wr_en = 1'b1;
                wr_addr = SP_W'(level_reg - LVL_W'(2));
                wr_data = alu_q;
                level_next = level_reg - LVL_W'(1);
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'd48)
                begin
                    wr_en = 1'b1;
                    wr_addr = SP_W'(level_reg - LVL_W'(2));
                    wr_data = alu_q;
                    level_next = level_reg - LVL_W'(1);
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: state_next = ST_BOTTOM;
            ST_BOTTOM:
            begin
                state_next = ST_OUT;
                level_next = '0;
                used_next = '0;
                fault_next = 1'b0;
            end
            ST_OUT:
            begin
                if (res.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tok_fire)
            tok_idx_reg <= tok.param_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= '0;
            used_reg <= '0;
            fault_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            used_reg <= used_next;
            fault_reg <= fault_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            dq_reg <= {(rd_a[31] ? 32'(-rd_a) : 32'(rd_a)), 16'd0};
            dvs_reg <= rd_b[31] ? 32'(-rd_b) : 32'(rd_b);
            rem_reg <= '0;
            cnt_reg <= '0;
            neg_reg <= rd_a[31] ^ rd_b[31];
        end
        else if (state_reg == ST_DIV && cnt_reg != 6'd48)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (!rem_try[32])
            begin
                rem_reg <= rem_try;
                dq_reg <= {dq_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[31:0], dq_reg[47]};
                dq_reg <= {dq_reg[46:0], 1'b0};
            end
        end
        if (state_reg == ST_BOTTOM)
        begin
            if (used_reg > npar_reg)
            begin
                res_reg <= '0;
                err_reg <= ERR_PARAM;
            end
            else if (fault_reg || level_reg == '0)
            begin
                res_reg <= '0;
                err_reg <= ERR_STACK;
            end
            else
            begin
                res_reg <= rd_a;
                err_reg <= ERR_OK;
            end
        end
    end

    assign a_reg = rd_a;
    assign b_reg = rd_b;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
            prod_reg <= 64'(rd_a) * 64'(rd_b);
    end

    `RPN_ASSERT_IMPL(a_ready_idle, tok.ready, !res.valid, "ready while result pending")
    `RPN_ASSERT_IMPL(a_level_range, 1'b1, 32'(level_reg) <= STACK_DEPTH, "stack level out of range")
    `RPN_ASSERT_NEXT(a_fin_clears, state_reg == ST_BOTTOM,
                     level_reg == '0 && used_reg == '0 && !fault_reg, "expression state not cleared")

endmodule
